/* rtl/core/dss_pkg.sv */
package dss_pkg;

  localparam int MAX_REQ = 16;
  localparam int IDX_W   = $clog2(MAX_REQ);
  localparam int CNT_W   = $clog2(MAX_REQ + 1);
  localparam int TRK_W   = 7;
  localparam int SEEK_W  = 11;
  localparam int MODE_W  = 3;

  localparam logic [TRK_W-1:0]  TOP_TRACK = 7'd99;
  localparam logic [SEEK_W-1:0] SEEK_MAX  = 11'd2047;

  localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLOOK = 3'd4;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_START = 1'b1;

  localparam logic [1:0] DIR_ANY   = 2'd0;
  localparam logic [1:0] DIR_ABOVE = 2'd1;
  localparam logic [1:0] DIR_BELOW = 2'd2;

  localparam logic [1:0] KEY_DIST  = 2'd0;
  localparam logic [1:0] KEY_ZERO  = 2'd1;
  localparam logic [1:0] KEY_TRACK = 2'd2;

  typedef struct packed {
    logic             load;
    logic             init;
    logic             scan_start;
    logic             scan_step;
    logic [1:0]       dir;
    logic [1:0]       key;
    logic             stage;
    logic             stage_pick;
    logic [TRK_W-1:0] stage_trk;
    logic             stage_req;
    logic             jump;
    logic             floor0;
    logic             flush;
    logic             clear;
  } dss_cmd_t;

  typedef struct packed {
    logic              found;
    logic              scan_last;
    logic              all_served;
    logic              head_zero;
    logic              head_top;
    logic              out_free;
    logic              hold_v;
    logic [MODE_W-1:0] mode;
  } dss_stat_t;

  function automatic logic [TRK_W-1:0] clamp_trk(input logic [TRK_W-1:0] t);
    clamp_trk = (t > TOP_TRACK) ? TOP_TRACK : t;
  endfunction

  function automatic logic [TRK_W-1:0] trk_dist(input logic [TRK_W-1:0] a,
                                                 input logic [TRK_W-1:0] b);
    trk_dist = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/core/dss_datapath.sv */
module dss_datapath
  import dss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dss_cmd_t            cmd,
  output dss_stat_t           stat,
  input  logic [TRK_W-1:0]    in_trk,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [TRK_W-1:0]    cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TRK_W-1:0]    out_trk,
  output logic [SEEK_W-1:0]   out_seek,
  output logic                out_req,
  output logic                out_last
);

  logic [TRK_W-1:0]   store_r [MAX_REQ];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [MAX_REQ-1:0] served_r, served_nxt;
  logic [TRK_W-1:0]   head_r, head_nxt;
  logic [SEEK_W-1:0]  travel_r, travel_nxt;
  logic [TRK_W-1:0]   floor_r, floor_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [TRK_W-1:0]   start_r, start_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [TRK_W-1:0]   best_trk_r, best_trk_nxt;
  logic [TRK_W-1:0]   best_key_r, best_key_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [TRK_W-1:0]   hold_trk_r, hold_trk_nxt;
  logic [SEEK_W-1:0]  hold_seek_r, hold_seek_nxt;
  logic               hold_req_r, hold_req_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TRK_W-1:0]   out_trk_r, out_trk_nxt;
  logic [SEEK_W-1:0]  out_seek_r, out_seek_nxt;
  logic               out_req_r, out_req_nxt;
  logic               out_last_r, out_last_nxt;

  logic               store_we;
  logic [TRK_W-1:0]   cur_trk;
  logic               elig;
  logic [TRK_W-1:0]   cur_key;
  logic [TRK_W-1:0]   stage_t;
  logic [TRK_W-1:0]   mv_trk;
  logic [SEEK_W:0]    seek_sum;
  logic [SEEK_W-1:0]  seek_sat;
  logic [MAX_REQ-1:0] full_mask;

  assign cur_trk = store_r[idx_r];
  assign stage_t = cmd.stage_pick ? best_trk_r : cmd.stage_trk;
  assign mv_trk  = cmd.jump ? best_trk_r : stage_t;
  assign seek_sum = {1'b0, travel_r} + {{(SEEK_W-TRK_W+1){1'b0}}, trk_dist(head_r, mv_trk)};
  assign seek_sat = seek_sum[SEEK_W] ? SEEK_MAX : seek_sum[SEEK_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_REQ; i++) begin
      full_mask[i] = (CNT_W'(i) < count_r);
    end
  end

  always_comb begin
    elig = !served_r[idx_r];
    if (cmd.dir == DIR_ABOVE && cur_trk < floor_r) elig = 1'b0;
    if (cmd.dir == DIR_BELOW && cur_trk > floor_r) elig = 1'b0;
    case (cmd.key)
      KEY_ZERO:  cur_key = '0;
      KEY_TRACK: cur_key = cur_trk;
      default:   cur_key = trk_dist(head_r, cur_trk);
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    served_nxt    = served_r;
    head_nxt      = head_r;
    travel_nxt    = travel_r;
    floor_nxt     = floor_r;
    mode_nxt      = mode_r;
    start_nxt     = start_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_trk_nxt  = best_trk_r;
    best_key_nxt  = best_key_r;
    hold_v_nxt    = hold_v_r;
    hold_trk_nxt  = hold_trk_r;
    hold_seek_nxt = hold_seek_r;
    hold_req_nxt  = hold_req_r;
    out_valid_nxt = out_valid_r;
    out_trk_nxt   = out_trk_r;
    out_seek_nxt  = out_seek_r;
    out_req_nxt   = out_req_r;
    out_last_nxt  = out_last_r;
    store_we      = 1'b0;

    if (cfg_we) begin
      if (cfg_addr == REG_MODE) mode_nxt = cfg_wdata[MODE_W-1:0];
      else start_nxt = cfg_wdata;
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (cmd.load && count_r < CNT_W'(MAX_REQ)) begin
      store_we  = 1'b1;
      count_nxt = count_r + 1'b1;
    end

    if (cmd.init) begin
      head_nxt   = clamp_trk(start_r);
      floor_nxt  = clamp_trk(start_r);
      travel_nxt = '0;
      served_nxt = '0;
      hold_v_nxt = 1'b0;
    end

    if (cmd.scan_start) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end

    if (cmd.scan_step) begin
      idx_nxt = idx_r + 1'b1;
      if (elig && (!found_r || cur_key < best_key_r)) begin
        found_nxt    = 1'b1;
        best_idx_nxt = idx_r;
        best_trk_nxt = cur_trk;
        best_key_nxt = cur_key;
      end
    end

    if (cmd.stage) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_trk_nxt   = hold_trk_r;
        out_seek_nxt  = hold_seek_r;
        out_req_nxt   = hold_req_r;
        out_last_nxt  = 1'b0;
      end
      hold_v_nxt    = 1'b1;
      hold_trk_nxt  = stage_t;
      hold_seek_nxt = seek_sat;
      hold_req_nxt  = cmd.stage_req;
      travel_nxt    = seek_sat;
      head_nxt      = stage_t;
      if (cmd.stage_pick) served_nxt[best_idx_r] = 1'b1;
    end

    if (cmd.jump) begin
      travel_nxt = seek_sat;
      head_nxt   = best_trk_r;
    end

    if (cmd.floor0) floor_nxt = '0;

    if (cmd.flush && hold_v_r) begin
      out_valid_nxt = 1'b1;
      out_trk_nxt   = hold_trk_r;
      out_seek_nxt  = hold_seek_r;
      out_req_nxt   = hold_req_r;
      out_last_nxt  = 1'b1;
      hold_v_nxt    = 1'b0;
    end

    if (cmd.clear) begin
      count_nxt  = '0;
      served_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) store_r[count_r[IDX_W-1:0]] <= clamp_trk(in_trk);
    best_idx_r  <= best_idx_nxt;
    best_trk_r  <= best_trk_nxt;
    best_key_r  <= best_key_nxt;
    idx_r       <= idx_nxt;
    hold_trk_r  <= hold_trk_nxt;
    hold_seek_r <= hold_seek_nxt;
    hold_req_r  <= hold_req_nxt;
    out_trk_r   <= out_trk_nxt;
    out_seek_r  <= out_seek_nxt;
    out_req_r   <= out_req_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      count_r     <= '0;
      served_r    <= '0;
      head_r      <= '0;
      travel_r    <= '0;
      floor_r     <= '0;
      mode_r      <= MODE_FCFS;
      start_r     <= '0;
      found_r     <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      served_r    <= served_nxt;
      head_r      <= head_nxt;
      travel_r    <= travel_nxt;
      floor_r     <= floor_nxt;
      mode_r      <= mode_nxt;
      start_r     <= start_nxt;
      found_r     <= found_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.found      = found_r;
  assign stat.scan_last  = ({1'b0, idx_r} == count_r - 1'b1);
  assign stat.all_served = (served_r == full_mask);
  assign stat.head_zero  = (head_r == '0);
  assign stat.head_top   = (head_r == TOP_TRACK);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.hold_v     = hold_v_r;
  assign stat.mode       = mode_r;

  assign out_valid = out_valid_r;
  assign out_trk   = out_trk_r;
  assign out_seek  = out_seek_r;
  assign out_req   = out_req_r;
  assign out_last  = out_last_r;

endmodule

/* rtl/core/dss_ctrl.sv */
module dss_ctrl
  import dss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  dss_stat_t stat,
  output dss_cmd_t  cmd
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_SBEG  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_PICK  = 3'd4;
  localparam logic [2:0] ST_ETOP  = 3'd5;
  localparam logic [2:0] ST_EZERO = 3'd6;
  localparam logic [2:0] ST_FLUSH = 3'd7;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_MIN    = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       can_stage;

  assign in_ready  = (state_r == ST_LOAD);
  assign can_stage = !stat.hold_v || stat.out_free;

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    cmd.load        = 1'b0;
    cmd.init        = 1'b0;
    cmd.scan_start  = 1'b0;
    cmd.scan_step   = 1'b0;
    cmd.stage       = 1'b0;
    cmd.stage_pick  = 1'b0;
    cmd.stage_trk   = '0;
    cmd.stage_req   = 1'b0;
    cmd.jump        = 1'b0;
    cmd.floor0      = 1'b0;
    cmd.flush       = 1'b0;
    cmd.clear       = 1'b0;
    case (stat.mode)
      MODE_SSTF: begin
        cmd.dir = DIR_ANY;
        cmd.key = KEY_DIST;
      end
      MODE_SCAN: begin
        cmd.dir = (phase_r == PH_FIRST) ? DIR_BELOW : DIR_ABOVE;
        cmd.key = KEY_DIST;
      end
      MODE_CSCAN, MODE_CLOOK: begin
        cmd.dir = (phase_r == PH_MIN) ? DIR_ANY : DIR_ABOVE;
        cmd.key = (phase_r == PH_MIN) ? KEY_TRACK : KEY_DIST;
      end
      default: begin
        cmd.dir = DIR_ANY;
        cmd.key = KEY_ZERO;
      end
    endcase
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        phase_nxt = PH_FIRST;
        state_nxt = ST_SBEG;
      end
      ST_SBEG: begin
        cmd.scan_start = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (stat.found) begin
          if (phase_r == PH_MIN) begin
            cmd.jump   = 1'b1;
            cmd.floor0 = 1'b1;
            phase_nxt  = PH_SECOND;
            state_nxt  = ST_SBEG;
          end else if (can_stage) begin
            cmd.stage      = 1'b1;
            cmd.stage_pick = 1'b1;
            cmd.stage_req  = 1'b1;
            state_nxt      = ST_SBEG;
          end
        end else if (phase_r != PH_FIRST || stat.all_served) begin
          state_nxt = ST_FLUSH;
        end else begin
          case (stat.mode)
            MODE_SCAN: begin
              if (stat.head_zero) begin
                cmd.floor0 = 1'b1;
                phase_nxt  = PH_SECOND;
                state_nxt  = ST_SBEG;
              end else begin
                state_nxt = ST_EZERO;
              end
            end
            MODE_CSCAN: state_nxt = stat.head_top ? ST_EZERO : ST_ETOP;
            MODE_CLOOK: begin
              phase_nxt = PH_MIN;
              state_nxt = ST_SBEG;
            end
            default: state_nxt = ST_FLUSH;
          endcase
        end
      end
      ST_ETOP: begin
        if (can_stage) begin
          cmd.stage     = 1'b1;
          cmd.stage_trk = TOP_TRACK;
          state_nxt     = ST_EZERO;
        end
      end
      ST_EZERO: begin
        if (can_stage) begin
          cmd.stage  = 1'b1;
          cmd.floor0 = 1'b1;
          phase_nxt  = PH_SECOND;
          state_nxt  = ST_SBEG;
        end
      end
      ST_FLUSH: begin
        if (can_stage) begin
          cmd.flush = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      phase_r <= PH_FIRST;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

/* rtl/core/disk_seek_scheduler.sv */
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tdata: track[6:0]; tlast: last_request
// out     | out | out_tvalid/tready  | tdata: head_track[6:0], total_seek[17:7];
//         |     |                    | tuser: is_request; tlast: end_of_run
// cfg     | in  | cfg_we             | cfg_addr 0 mode, 1 start_track
// Requests load one word a cycle while in the load state. Each visit scans
// every stored request, one entry a cycle, plus a further scan for the
// C-LOOK jump. One visit is held back to mark the end of the run.
// Reset clears the batch and the state registers, not the data registers; the output register decouples stalls.
module disk_seek_scheduler
  import dss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // track[6:0], pad[7]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // head_track[6:0], total_seek[17:7], pad[23:18]
  output logic        out_tuser,  // is_request
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata
);

  dss_cmd_t          cmd;
  dss_stat_t         stat;
  logic [TRK_W-1:0]  o_trk;
  logic [SEEK_W-1:0] o_seek;

  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dss_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_trk    (in_tdata[TRK_W-1:0]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_trk   (o_trk),
    .out_seek  (o_seek),
    .out_req   (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'd0, o_seek, o_trk};

endmodule
